>>> design/setup_text_tokenizer_assert.svh
// assertion macros for the setup text tokenizer
// no dependencies; included by the top level only
`ifndef SETUP_TEXT_TOKENIZER_ASSERT_SVH
`define SETUP_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/stt_pkg.sv
// types and constants of the setup text tokenizer
// no dependencies; used by setup_text_tokenizer
package stt_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    localparam logic [3:0] K_END       = 4'd0;
    localparam logic [3:0] K_OPEN      = 4'd1;
    localparam logic [3:0] K_CLOSE     = 4'd2;
    localparam logic [3:0] K_IDENT_END = 4'd3;
    localparam logic [3:0] K_STR_END   = 4'd4;
    localparam logic [3:0] K_INTEGER   = 4'd5;
    localparam logic [3:0] K_DECIMAL   = 4'd6;
    localparam logic [3:0] K_OTHER     = 4'd7;
    localparam logic [3:0] K_IDENT_CH  = 4'd8;
    localparam logic [3:0] K_STR_CH    = 4'd9;

    localparam logic [7:0] C_SPACE_LIM = 8'd33;
    localparam logic [7:0] C_OPEN      = 8'h5B;
    localparam logic [7:0] C_CLOSE     = 8'h5D;
    localparam logic [7:0] C_MINUS     = 8'h2D;
    localparam logic [7:0] C_POINT     = 8'h2E;
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BSLASH    = 8'h5C;
    localparam logic [7:0] C_NUL       = 8'h00;

    localparam logic [34:0] MAG_MAX = 35'h0_7FFF_FFFF;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_IDENT = 7'b0000010,
        M_MINUS = 7'b0000100,
        M_INT   = 7'b0001000,
        M_FRAC  = 7'b0010000,
        M_STR   = 7'b0100000,
        M_ESC   = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  text_char;
        logic [30:0] magnitude;
        logic        is_negative;
        logic [29:0] frac_mantissa;
        logic [3:0]  frac_count;
        logic        last;
    } t_result;

endpackage

>>> design/setup_text_tokenizer.sv
// setup text tokenizer: one byte per cycle in, tokens out through a 4-word queue
// tokens are registered into the queue when their byte is accepted; the output shows the queue head
// throughput: one byte per cycle; input stalls while fewer than two queue slots are free
// reset: synchronous active low; lexer idle, number state cleared, queue empty
// depends on stt_pkg and setup_text_tokenizer_assert.svh
module setup_text_tokenizer #(
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_text_char,
    output logic [30:0] o_magnitude,
    output logic        o_is_negative,
    output logic [29:0] o_frac_mantissa,
    output logic [3:0]  o_frac_count,
    output logic        o_last
);

`include "setup_text_tokenizer_assert.svh"

    localparam logic [3:0] FRAC_LIM = 4'(MAX_FRAC_DIGITS);

    stt_pkg::t_mode r_mode, n_mode;
    logic           r_minus, n_minus;
    logic [30:0]    r_int, n_int;
    logic [29:0]    r_frac, n_frac;
    logic [3:0]     r_fcnt, n_fcnt;

    stt_pkg::t_result r_fifo [stt_pkg::FIFO_DEPTH];
    logic [stt_pkg::PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [stt_pkg::CNT_W-1:0] r_count;

    stt_pkg::t_result res0, res1, ires;
    logic has0, has1, ihas, do_idle;
    logic in_acc, out_acc;
    logic [7:0] c;
    logic eof, c_digit, c_letter;
    logic [3:0] dval;
    logic [34:0] int_prod;
    logic [33:0] frac_prod;
    logic [stt_pkg::CNT_W-1:0] push_n;
    stt_pkg::t_result head;

    function automatic stt_pkg::t_result mk(input logic [3:0] k, input logic [7:0] ch);
        stt_pkg::t_result r;
        r = '0;
        r.kind = k;
        r.text_char = ch;
        return r;
    endfunction

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign o_stall  = r_count > stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2);
    assign o_valid  = r_count != '0;

    assign c        = i_data_byte;
    assign eof      = i_end_of_input;
    assign c_digit  = (c >= 8'h30) && (c <= 8'h39);
    assign c_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                      || (c == 8'h5F);
    assign dval     = c[3:0];
    assign int_prod = {1'b0, r_int, 3'b000} + {3'b000, r_int, 1'b0} + {31'd0, dval};
    assign frac_prod = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0} + {30'd0, dval};

    always_comb begin
        n_mode  = r_mode;
        n_minus = r_minus;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        res0    = '0;
        res1    = '0;
        ires    = '0;
        has0    = 1'b0;
        has1    = 1'b0;
        ihas    = 1'b0;
        do_idle = 1'b0;

        case (r_mode)
            stt_pkg::M_IDENT: begin
                if (!eof && (c_letter || c_digit)) begin
                    res0 = mk(stt_pkg::K_IDENT_CH, c);
                    has0 = 1'b1;
                end else begin
                    res0 = mk(stt_pkg::K_IDENT_END, 8'd0);
                    has0 = 1'b1;
                    do_idle = 1'b1;
                end
            end
            stt_pkg::M_MINUS: begin
                if (!eof && c_digit) begin
                    n_int  = {27'd0, dval};
                    n_mode = stt_pkg::M_INT;
                end else begin
                    n_minus = 1'b0;
                    n_int   = '0;
                    n_frac  = '0;
                    n_fcnt  = '0;
                    res0    = mk(stt_pkg::K_OTHER, 8'd0);
                    has0    = 1'b1;
                    do_idle = 1'b1;
                end
            end
            stt_pkg::M_INT: begin
                if (!eof && c_digit) begin
                    n_int = (int_prod > stt_pkg::MAG_MAX) ? stt_pkg::MAG_MAX[30:0]
                                                          : int_prod[30:0];
                end else if (!eof && c == stt_pkg::C_POINT) begin
                    n_frac = '0;
                    n_fcnt = '0;
                    n_mode = stt_pkg::M_FRAC;
                end else begin
                    res0 = mk(stt_pkg::K_INTEGER, 8'd0);
                    res0.magnitude   = r_int;
                    res0.is_negative = r_minus;
                    has0    = 1'b1;
                    n_minus = 1'b0;
                    n_int   = '0;
                    n_frac  = '0;
                    n_fcnt  = '0;
                    do_idle = 1'b1;
                end
            end
            stt_pkg::M_FRAC: begin
                if (!eof && c_digit) begin
                    if (r_fcnt < FRAC_LIM) begin
                        n_frac = frac_prod[29:0];
                        n_fcnt = r_fcnt + 4'd1;
                    end
                end else begin
                    res0 = mk(stt_pkg::K_DECIMAL, 8'd0);
                    res0.magnitude     = r_int;
                    res0.is_negative   = r_minus;
                    res0.frac_mantissa = r_frac;
                    res0.frac_count    = r_fcnt;
                    has0    = 1'b1;
                    n_minus = 1'b0;
                    n_int   = '0;
                    n_frac  = '0;
                    n_fcnt  = '0;
                    do_idle = 1'b1;
                end
            end
            stt_pkg::M_STR: begin
                has0 = 1'b1;
                if (eof || c == stt_pkg::C_NUL) begin
                    n_mode = stt_pkg::M_IDLE;
                    res0   = mk(stt_pkg::K_END, 8'd0);
                end else if (c == stt_pkg::C_QUOTE) begin
                    n_mode = stt_pkg::M_IDLE;
                    res0   = mk(stt_pkg::K_STR_END, 8'd0);
                end else if (c == stt_pkg::C_BSLASH) begin
                    n_mode = stt_pkg::M_ESC;
                    has0   = 1'b0;
                end else begin
                    res0 = mk(stt_pkg::K_STR_CH, c);
                end
            end
            stt_pkg::M_ESC: begin
                has0 = 1'b1;
                if (eof) begin
                    n_mode = stt_pkg::M_IDLE;
                    res0   = mk(stt_pkg::K_END, 8'd0);
                end else begin
                    n_mode = stt_pkg::M_STR;
                    res0   = mk(stt_pkg::K_STR_CH, c);
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            n_mode = stt_pkg::M_IDLE;
            ihas   = 1'b1;
            if (eof) begin
                ires = mk(stt_pkg::K_END, 8'd0);
            end else if (c < stt_pkg::C_SPACE_LIM) begin
                ihas = 1'b0;
            end else if (c == stt_pkg::C_OPEN) begin
                ires = mk(stt_pkg::K_OPEN, 8'd0);
            end else if (c == stt_pkg::C_CLOSE) begin
                ires = mk(stt_pkg::K_CLOSE, 8'd0);
            end else if (c_letter) begin
                ires   = mk(stt_pkg::K_IDENT_CH, c);
                n_mode = stt_pkg::M_IDENT;
            end else if (c == stt_pkg::C_MINUS) begin
                ihas    = 1'b0;
                n_minus = 1'b1;
                n_int   = '0;
                n_frac  = '0;
                n_fcnt  = '0;
                n_mode  = stt_pkg::M_MINUS;
            end else if (c_digit) begin
                ihas    = 1'b0;
                n_minus = 1'b0;
                n_int   = {27'd0, dval};
                n_frac  = '0;
                n_fcnt  = '0;
                n_mode  = stt_pkg::M_INT;
            end else if (c == stt_pkg::C_QUOTE) begin
                ihas   = 1'b0;
                n_mode = stt_pkg::M_STR;
            end else begin
                ires = mk(stt_pkg::K_OTHER, 8'd0);
            end
            if (has0) begin
                res1 = ires;
                has1 = ihas;
            end else begin
                res0 = ires;
                has0 = ihas;
            end
        end

        if (has1) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    assign push_n = in_acc ? (stt_pkg::CNT_W'(has0) + stt_pkg::CNT_W'(has1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stt_pkg::M_IDLE;
            r_minus  <= 1'b0;
            r_int    <= '0;
            r_frac   <= '0;
            r_fcnt   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_mode  <= n_mode;
                r_minus <= n_minus;
                r_int   <= n_int;
                r_frac  <= n_frac;
                r_fcnt  <= n_fcnt;
            end
            r_wr_ptr <= r_wr_ptr + push_n[stt_pkg::PTR_W-1:0];
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + stt_pkg::PTR_W'(1);
            end
            r_count <= r_count + push_n - stt_pkg::CNT_W'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && has0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_acc && has1) begin
            r_fifo[r_wr_ptr + stt_pkg::PTR_W'(1)] <= res1;
        end
    end

    assign head            = r_fifo[r_rd_ptr];
    assign o_kind          = head.kind;
    assign o_text_char     = head.text_char;
    assign o_magnitude     = head.magnitude;
    assign o_is_negative   = head.is_negative;
    assign o_frac_mantissa = head.frac_mantissa;
    assign o_frac_count    = head.frac_count;
    assign o_last          = head.last;

    `STT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH), "queue count beyond depth")
    `STT_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, out_acc && !in_acc,
        r_count == $past(r_count) - 3'd1, "queue count did not drop on pop")
    `STT_ASSERT_NEXT(a_eof_idle, i_clk, i_rst_n, in_acc && i_end_of_input,
        r_mode == stt_pkg::M_IDLE, "lexer not idle after end of input")

endmodule

>>> tb/setup_text_tokenizer_tb.sv
`timescale 1ns / 100ps
// testbench for setup_text_tokenizer: directed and random text words against a token predictor
// depends on stt_pkg and the setup_text_tokenizer rtl
module setup_text_tokenizer_tb;

    localparam int FRAC_LIMIT = 9;
    localparam int TEXT_WORDS = 1500;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
    } t_text_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_kind;
    logic [7:0]  o_text_char;
    logic [30:0] o_magnitude;
    logic        o_is_negative;
    logic [29:0] o_frac_mantissa;
    logic [3:0]  o_frac_count;
    logic        o_last;

    t_text_word        text_words[$];
    stt_pkg::t_result  expected_tokens[$];
    stt_pkg::t_result  step_tokens[2];
    int                step_count;
    t_text_word        held_word;

    stt_pkg::t_mode lex_state = stt_pkg::M_IDLE;
    logic        num_negative = 1'b0;
    logic [30:0] int_mag = '0;
    logic [29:0] frac_val = '0;
    logic [3:0]  frac_cnt = '0;

    int          words_accepted = 0;
    int          tokens_checked = 0;
    int          mismatch_count = 0;
    int          blank_words = 0;

    setup_text_tokenizer #(
        .MAX_FRAC_DIGITS(FRAC_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .i_end_of_input(i_end_of_input),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_kind(o_kind),
        .o_text_char(o_text_char),
        .o_magnitude(o_magnitude),
        .o_is_negative(o_is_negative),
        .o_frac_mantissa(o_frac_mantissa),
        .o_frac_count(o_frac_count),
        .o_last(o_last)
    );

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void emit_token(logic [3:0] kind, logic [7:0] ch, logic [30:0] mag,
                             logic neg, logic [29:0] mant, logic [3:0] cnt);
        step_tokens[step_count] = '{kind, ch, mag, neg, mant, cnt, 1'b0};
        step_count++;
    endfunction

    function void clear_number();
        num_negative = 1'b0;
        int_mag = '0;
        frac_val = '0;
        frac_cnt = '0;
    endfunction

    function void lex_from_idle(logic [7:0] c, logic eof);
        lex_state = stt_pkg::M_IDLE;
        if (eof) begin
            emit_token(stt_pkg::K_END, '0, '0, 1'b0, '0, '0);
        end else if (c >= stt_pkg::C_SPACE_LIM) begin
            if (c == stt_pkg::C_OPEN) begin
                emit_token(stt_pkg::K_OPEN, '0, '0, 1'b0, '0, '0);
            end else if (c == stt_pkg::C_CLOSE) begin
                emit_token(stt_pkg::K_CLOSE, '0, '0, 1'b0, '0, '0);
            end else if (is_alpha(c)) begin
                lex_state = stt_pkg::M_IDENT;
                emit_token(stt_pkg::K_IDENT_CH, c, '0, 1'b0, '0, '0);
            end else if (c == stt_pkg::C_MINUS) begin
                clear_number();
                num_negative = 1'b1;
                lex_state = stt_pkg::M_MINUS;
            end else if (is_num(c)) begin
                clear_number();
                int_mag = 31'(c - "0");
                lex_state = stt_pkg::M_INT;
            end else if (c == stt_pkg::C_QUOTE) begin
                lex_state = stt_pkg::M_STR;
            end else begin
                emit_token(stt_pkg::K_OTHER, '0, '0, 1'b0, '0, '0);
            end
        end
    endfunction

    function void lex_word(logic [7:0] c, logic eof);
        logic [34:0]      wide;
        stt_pkg::t_result tok;
        step_count = 0;
        case (lex_state)
            stt_pkg::M_IDENT: begin
                if (!eof && (is_alpha(c) || is_num(c))) begin
                    emit_token(stt_pkg::K_IDENT_CH, c, '0, 1'b0, '0, '0);
                end else begin
                    emit_token(stt_pkg::K_IDENT_END, '0, '0, 1'b0, '0, '0);
                    lex_from_idle(c, eof);
                end
            end
            stt_pkg::M_MINUS: begin
                if (!eof && is_num(c)) begin
                    int_mag = 31'(c - "0");
                    lex_state = stt_pkg::M_INT;
                end else begin
                    clear_number();
                    emit_token(stt_pkg::K_OTHER, '0, '0, 1'b0, '0, '0);
                    lex_from_idle(c, eof);
                end
            end
            stt_pkg::M_INT: begin
                if (!eof && is_num(c)) begin
                    wide = {4'd0, int_mag} * 35'd10 + 35'(c - "0");
                    int_mag = (wide > stt_pkg::MAG_MAX) ? stt_pkg::MAG_MAX[30:0]
                                                         : wide[30:0];
                end else if (!eof && c == stt_pkg::C_POINT) begin
                    frac_val = '0;
                    frac_cnt = '0;
                    lex_state = stt_pkg::M_FRAC;
                end else begin
                    emit_token(stt_pkg::K_INTEGER, '0, int_mag, num_negative, '0, '0);
                    clear_number();
                    lex_from_idle(c, eof);
                end
            end
            stt_pkg::M_FRAC: begin
                if (!eof && is_num(c)) begin
                    if (frac_cnt < FRAC_LIMIT) begin
                        frac_val = frac_val * 30'd10 + 30'(c - "0");
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end else begin
                    emit_token(stt_pkg::K_DECIMAL, '0, int_mag, num_negative,
                               frac_val, frac_cnt);
                    clear_number();
                    lex_from_idle(c, eof);
                end
            end
            stt_pkg::M_STR: begin
                if (eof || c == stt_pkg::C_NUL) begin
                    lex_state = stt_pkg::M_IDLE;
                    emit_token(stt_pkg::K_END, '0, '0, 1'b0, '0, '0);
                end else if (c == stt_pkg::C_QUOTE) begin
                    lex_state = stt_pkg::M_IDLE;
                    emit_token(stt_pkg::K_STR_END, '0, '0, 1'b0, '0, '0);
                end else if (c == stt_pkg::C_BSLASH) begin
                    lex_state = stt_pkg::M_ESC;
                end else begin
                    emit_token(stt_pkg::K_STR_CH, c, '0, 1'b0, '0, '0);
                end
            end
            stt_pkg::M_ESC: begin
                if (eof) begin
                    lex_state = stt_pkg::M_IDLE;
                    emit_token(stt_pkg::K_END, '0, '0, 1'b0, '0, '0);
                end else begin
                    lex_state = stt_pkg::M_STR;
                    emit_token(stt_pkg::K_STR_CH, c, '0, 1'b0, '0, '0);
                end
            end
            default: begin
                lex_from_idle(c, eof);
            end
        endcase
        for (int i = 0; i < step_count; i++) begin
            tok = step_tokens[i];
            tok.last = (i == step_count - 1);
            expected_tokens.push_back(tok);
        end
    endfunction

    function automatic bit idle_draw(int progress);
        if (progress >= 500 && progress < 800) begin
            return 1'b0;
        end
        return $urandom_range(99) < 33;
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = int'($urandom_range(52));
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end
        return "_";
    endfunction

    task automatic push_byte(logic [7:0] c);
        text_words.push_back('{c, 1'b0});
    endtask

    task automatic push_eof();
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        text_words.push_back('{junk, 1'b1});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    task automatic queue_random_token();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = int'($urandom_range(99));
        if (pick < 10) begin
            n = int'($urandom_range(1, 3));
            blank_words += n;
            repeat (n) push_byte(8'($urandom_range(32)));
        end else if (pick < 22) begin
            push_byte($urandom_range(1) ? stt_pkg::C_OPEN : stt_pkg::C_CLOSE);
        end else if (pick < 42) begin
            push_byte(rand_alpha());
            n = int'($urandom_range(8));
            repeat (n) begin
                push_byte($urandom_range(2) == 0 ? 8'("0" + $urandom_range(9)) : rand_alpha());
            end
        end else if (pick < 60) begin
            push_byte(stt_pkg::C_QUOTE);
            n = int'($urandom_range(10));
            repeat (n) begin
                b = 8'($urandom_range(1, 255));
                if (b == stt_pkg::C_QUOTE || b == stt_pkg::C_BSLASH
                        || $urandom_range(9) == 0) begin
                    push_byte(stt_pkg::C_BSLASH);
                    b = 8'($urandom_range(255));
                end
                push_byte(b);
            end
            n = int'($urandom_range(19));
            if (n == 0) begin
                push_byte(stt_pkg::C_NUL);
            end else if (n == 1) begin
                push_eof();
            end else if (n == 2) begin
                push_byte(stt_pkg::C_BSLASH);
                push_eof();
            end else begin
                push_byte(stt_pkg::C_QUOTE);
            end
        end else if (pick < 82) begin
            if ($urandom_range(2) == 0) begin
                push_byte(stt_pkg::C_MINUS);
            end
            n = int'(($urandom_range(7) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4));
            repeat (n) push_byte(8'("0" + $urandom_range(9)));
            if ($urandom_range(1)) begin
                push_byte(stt_pkg::C_POINT);
                n = int'(($urandom_range(7) == 0) ? $urandom_range(8, 12)
                                                  : $urandom_range(0, 4));
                repeat (n) push_byte(8'("0" + $urandom_range(9)));
            end
        end else if (pick < 87) begin
            push_byte(stt_pkg::C_MINUS);
            push_byte(8'($urandom_range(255)));
        end else if (pick < 96) begin
            push_byte(8'($urandom_range(255)));
        end else begin
            push_eof();
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_token();
        stt_pkg::t_result want;
        if (expected_tokens.size() == 0) begin
            $display("%0t: token kind %0h with none expected", $time, o_kind);
            mismatch_count++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 32'(want.kind), 32'(o_kind));
            check_field("text_char", 32'(want.text_char), 32'(o_text_char));
            check_field("magnitude", 32'(want.magnitude), 32'(o_magnitude));
            check_field("is_negative", 32'(want.is_negative), 32'(o_is_negative));
            check_field("frac_mantissa", 32'(want.frac_mantissa), 32'(o_frac_mantissa));
            check_field("frac_count", 32'(want.frac_count), 32'(o_frac_count));
            check_field("last", 32'(want.last), 32'(o_last));
        end
        tokens_checked++;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                lex_word(held_word.ch, held_word.eof);
                words_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (text_words.size() != 0 && !idle_draw(words_accepted)) begin
                    held_word = text_words.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= held_word.ch;
                    i_end_of_input <= held_word.eof;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_token();
            end
            i_stall <= idle_draw(tokens_checked);
        end
    end

    initial begin
        // brackets, ident split by minus, other bytes, escapes and zero in a string
        push_text("[ a9-x]#\"\\");
        push_byte(stt_pkg::C_NUL);
        push_byte(8'hFF);
        push_byte(stt_pkg::C_NUL);
        // saturated magnitude with a fraction past the digit limit
        push_text("-9999999999.1234567890]");
        push_eof();
        push_text("\"");
        push_eof();
        push_text("7.");
        push_eof();
        push_text("\"\\");
        push_eof();
        while (text_words.size() - blank_words < TEXT_WORDS) begin
            queue_random_token();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (text_words.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("run covered %0d text words and %0d checked tokens",
                 words_accepted, tokens_checked);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("setup_text_tokenizer_tb: done, clean");
        end else begin
            $display("setup_text_tokenizer_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("setup_text_tokenizer_tb: done, errors");
        $finish;
    end

endmodule
